// File: rtl/core/board_occupancy_change_detector_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the board occupancy change detector
// Clocked implication checks, gated off during reset.
// ---------------------------------------------------------------------------
`ifndef BOARD_OCCUPANCY_CHANGE_DETECTOR_ASSERT_SVH
`define BOARD_OCCUPANCY_CHANGE_DETECTOR_ASSERT_SVH

// same-cycle implication
`define BOC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("board change detector check failed");

// next-cycle implication
`define BOC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("board change detector check failed");

`endif

// File: rtl/core/boc_pkg.sv
// ---------------------------------------------------------------------------
// boc_pkg
// Shared types and constants of the board occupancy change detector.
// ---------------------------------------------------------------------------
package boc_pkg;

   localparam int CELL_COUNT = 64;
   localparam int ADDR_W     = 6;
   localparam int SAMPLE_W   = 12;
   localparam int FILE_W     = 7;
   localparam int RANK_W     = 6;

   // ASCII bases: file letter counts down from 'h', rank counts up from '1'
   localparam logic [FILE_W-1:0]   FILE_BASE    = 7'd104;
   localparam logic [RANK_W-1:0]   RANK_BASE    = 6'd49;
   localparam logic [SAMPLE_W-1:0] THRESH_RESET = 12'd100;

   localparam logic ACTION_BIAS    = 1'b0;
   localparam logic ACTION_MEASURE = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_SHORT = 1'b1;

   // item held in the board update stage
   typedef struct packed {
      logic                action;
      logic                in_grid;
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] sample;
      logic                eos;
   } item_type;

   // end-of-scan snapshot handed to the encoder
   typedef struct packed {
      logic [CELL_COUNT-1:0] now_board;
      logic [CELL_COUNT-1:0] changed;
   } scan_type;

endpackage

// File: rtl/core/board_occupancy_change_detector.sv
// Path to rsp_valid: update stage, encoder snapshot, then output register.
// Throughput: one item per cycle unless stalled, via the single bias read port.
// Two move items can wait at the output; input stalls once both are held and
// the next ending measure item reaches the update stage.
// Reset: synchronous, active high; clears both boards and loads threshold 100.
// The bias memory is not cleared and holds unknown data until written.
// ---------------------------------------------------------------------------
// board_occupancy_change_detector
// Hall sensor grid occupancy tracking and move detection at end of scan.
// ---------------------------------------------------------------------------
`include "board_occupancy_change_detector_assert.svh"

module board_occupancy_change_detector #(
   parameter int GRID_SIDE = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // sample items
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [2:0]                    req_row,
   input  logic [2:0]                    req_col,
   input  logic [boc_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                          req_end_of_scan,
   // move items
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [boc_pkg::FILE_W-1:0]    rsp_from_file,
   output logic [boc_pkg::RANK_W-1:0]    rsp_from_rank,
   output logic [boc_pkg::FILE_W-1:0]    rsp_to_file,
   output logic [boc_pkg::RANK_W-1:0]    rsp_to_rank,
   output logic                          rsp_status,
   // threshold register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [boc_pkg::SAMPLE_W-1:0]  csr_wdata
);

   localparam logic [3:0] SIDE = 4'(GRID_SIDE);

   logic [boc_pkg::SAMPLE_W-1:0] threshold_ff;
   logic                         s1_valid_ff, s1_valid_in;
   boc_pkg::item_type            item_ff;
   logic                         req_in_grid;
   logic                         req_accept;
   logic [boc_pkg::ADDR_W-1:0]   req_addr;
   logic                         s1_res;
   logic                         s1_go;
   logic                         s2_ready;
   logic [boc_pkg::SAMPLE_W-1:0] bias_rd;
   boc_pkg::scan_type            scan;
   logic                         rsp_held;
   logic [26:0]                  rsp_payload;
   logic                         rsp_ok;
   logic                         move_distinct;
   logic                         s1_blocked;

   // input decode
   assign req_in_grid = ({1'b0, req_row} < SIDE) && ({1'b0, req_col} < SIDE);
   assign req_addr    = {req_row, req_col};
   assign req_accept  = req_valid && !req_stall;

   // update stage advance: result items need room in the encoder
   assign s1_res    = (item_ff.action == boc_pkg::ACTION_MEASURE) && item_ff.eos;
   assign s1_go     = s1_valid_ff && (!s1_res || s2_ready);
   assign req_stall = s1_valid_ff && !s1_go;

   // threshold register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= boc_pkg::THRESH_RESET;
      end else if (csr_valid && csr_ready) begin
         threshold_ff <= csr_wdata;
      end
   end

   // update stage occupancy
   assign s1_valid_in = req_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.action  <= req_action;
         item_ff.in_grid <= req_in_grid;
         item_ff.addr    <= req_addr;
         item_ff.sample  <= req_sample;
         item_ff.eos     <= req_end_of_scan;
      end
   end

   boc_bias_mem u_bias_mem (
      .clock   (clock),
      .wr_en   (req_accept && (req_action == boc_pkg::ACTION_BIAS) && req_in_grid),
      .wr_addr (req_addr),
      .wr_data (req_sample),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .rd_data (bias_rd)
   );

   boc_board_update u_board_update (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_go),
      .item      (item_ff),
      .bias      (bias_rd),
      .threshold (threshold_ff),
      .scan      (scan)
   );

   boc_move_encode u_move_encode (
      .clock         (clock),
      .reset         (reset),
      .load          (s1_go && s1_res),
      .scan_in       (scan),
      .ready         (s2_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_from_file (rsp_from_file),
      .rsp_from_rank (rsp_from_rank),
      .rsp_to_file   (rsp_to_file),
      .rsp_to_rank   (rsp_to_rank),
      .rsp_status    (rsp_status)
   );

   // check terms
   assign rsp_held      = rsp_valid && rsp_stall;
   assign rsp_payload   = {rsp_from_file, rsp_from_rank, rsp_to_file, rsp_to_rank, rsp_status};
   assign rsp_ok        = rsp_valid && (rsp_status == boc_pkg::STATUS_OK);
   assign move_distinct = (rsp_from_file != rsp_to_file) || (rsp_from_rank != rsp_to_rank);
   assign s1_blocked    = s1_valid_ff && s1_res && !s2_ready;

   // checks
   `BOC_ASSERT_IMP(a_stall_needs_item, clock, reset, req_stall, s1_valid_ff)
   `BOC_ASSERT_NXT(a_stalled_move_holds, clock, reset, rsp_held, rsp_valid && $stable(rsp_payload))
   `BOC_ASSERT_IMP(a_ok_means_two_squares, clock, reset, rsp_ok, move_distinct)
   `BOC_ASSERT_IMP(a_result_item_waits, clock, reset, s1_blocked, req_stall)

endmodule

// File: rtl/core/boc_bias_mem.sv
// ---------------------------------------------------------------------------
// boc_bias_mem
// Per-square bias store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module boc_bias_mem (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [boc_pkg::ADDR_W-1:0]    wr_addr,
   input  logic [boc_pkg::SAMPLE_W-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [boc_pkg::ADDR_W-1:0]    rd_addr,
   output logic [boc_pkg::SAMPLE_W-1:0]  rd_data
);

   logic [boc_pkg::SAMPLE_W-1:0] mem [boc_pkg::CELL_COUNT];
   logic [boc_pkg::SAMPLE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/boc_board_update.sv
// ---------------------------------------------------------------------------
// boc_board_update
// Threshold compare and read-modify-write of the scan and previous boards.
// ---------------------------------------------------------------------------
module boc_board_update (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  boc_pkg::item_type             item,
   input  logic [boc_pkg::SAMPLE_W-1:0]  bias,
   input  logic [boc_pkg::SAMPLE_W-1:0]  threshold,
   output boc_pkg::scan_type             scan
);

   logic [boc_pkg::CELL_COUNT-1:0] scan_board_ff, scan_board_in;
   logic [boc_pkg::CELL_COUNT-1:0] previous_board_ff, previous_board_in;
   logic [boc_pkg::SAMPLE_W:0]     diff;
   logic                           occupied;
   logic                           measure;
   logic [boc_pkg::CELL_COUNT-1:0] now_board;

   // signed difference sample - bias against the threshold
   assign diff     = {1'b0, item.sample} - {1'b0, bias};
   assign occupied = $signed(diff) > $signed({1'b0, threshold});
   assign measure  = (item.action == boc_pkg::ACTION_MEASURE);

   // board with this item's square applied
   always_comb begin
      now_board = scan_board_ff;
      if (measure && item.in_grid) begin
         now_board[item.addr] = occupied;
      end
   end

   // next state of both boards
   always_comb begin
      scan_board_in     = scan_board_ff;
      previous_board_in = previous_board_ff;
      if (step && measure) begin
         scan_board_in = now_board;
         if (item.eos) begin
            previous_board_in = now_board;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_board_ff     <= '0;
         previous_board_ff <= '0;
      end else begin
         scan_board_ff     <= scan_board_in;
         previous_board_ff <= previous_board_in;
      end
   end

   assign scan.now_board = now_board;
   assign scan.changed   = previous_board_ff ^ now_board;

endmodule

// File: rtl/core/boc_move_encode.sv
// ---------------------------------------------------------------------------
// boc_move_encode
// Finds first and last changed square column-major and registers the move.
// ---------------------------------------------------------------------------
module boc_move_encode (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  boc_pkg::scan_type             scan_in,
   output logic                          ready,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [boc_pkg::FILE_W-1:0]    rsp_from_file,
   output logic [boc_pkg::RANK_W-1:0]    rsp_from_rank,
   output logic [boc_pkg::FILE_W-1:0]    rsp_to_file,
   output logic [boc_pkg::RANK_W-1:0]    rsp_to_rank,
   output logic                          rsp_status
);

   logic                           s2_valid_ff, s2_valid_in;
   boc_pkg::scan_type              snap_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [boc_pkg::FILE_W-1:0]     from_file_ff, to_file_ff;
   logic [boc_pkg::RANK_W-1:0]     from_rank_ff, to_rank_ff;
   logic                           status_ff;
   logic                           out_free;
   logic                           s2_move;
   logic [boc_pkg::CELL_COUNT-1:0] col_major;
   logic [boc_pkg::ADDR_W-1:0]     lo_pos, hi_pos;
   logic                           any_chg;
   logic                           two_chg;
   logic [2:0]                     r1, c1, r2, c2;
   logic [2:0]                     fr, fc, tr, tc;

   // handshake between snapshot stage and output register
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s2_move  = s2_valid_ff && out_free;
   assign ready    = !s2_valid_ff || out_free;

   // reorder so bit c*8+r holds square (r, c)
   always_comb begin
      for (int r = 0; r < 8; r++) begin
         for (int c = 0; c < 8; c++) begin
            col_major[c*8 + r] = snap_ff.changed[r*8 + c];
         end
      end
   end

   // lowest and highest set position
   always_comb begin
      lo_pos  = '0;
      hi_pos  = '0;
      any_chg = 1'b0;
      for (int k = 0; k < boc_pkg::CELL_COUNT; k++) begin
         if (col_major[k] && !any_chg) begin
            lo_pos  = boc_pkg::ADDR_W'(k);
            any_chg = 1'b1;
         end
      end
      for (int k = 0; k < boc_pkg::CELL_COUNT; k++) begin
         if (col_major[k]) begin
            hi_pos = boc_pkg::ADDR_W'(k);
         end
      end
   end

   // squares not found count as row 0, col 0
   assign two_chg = any_chg && (lo_pos != hi_pos);
   assign r1 = lo_pos[2:0];
   assign c1 = lo_pos[5:3];
   assign r2 = two_chg ? hi_pos[2:0] : 3'd0;
   assign c2 = two_chg ? hi_pos[5:3] : 3'd0;

   // first changed square occupied now -> it is the destination
   always_comb begin
      if (snap_ff.now_board[{r1, c1}]) begin
         fr = r2; fc = c2; tr = r1; tc = c1;
      end else begin
         fr = r1; fc = c1; tr = r2; tc = c2;
      end
   end

   assign s2_valid_in  = load ? 1'b1 : (s2_move ? 1'b0 : s2_valid_ff);
   assign rsp_valid_in = out_free ? s2_valid_ff : rsp_valid_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         snap_ff <= scan_in;
      end
      if (s2_move) begin
         from_file_ff <= boc_pkg::FILE_BASE - {4'd0, fr};
         from_rank_ff <= boc_pkg::RANK_BASE + {3'd0, fc};
         to_file_ff   <= boc_pkg::FILE_BASE - {4'd0, tr};
         to_rank_ff   <= boc_pkg::RANK_BASE + {3'd0, tc};
         status_ff    <= two_chg ? boc_pkg::STATUS_OK : boc_pkg::STATUS_SHORT;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_from_file = from_file_ff;
   assign rsp_from_rank = from_rank_ff;
   assign rsp_to_file   = to_file_ff;
   assign rsp_to_rank   = to_rank_ff;
   assign rsp_status    = status_ff;

endmodule
